// ----- sv/sjbc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the step table of the servo jog block.
package sjbc_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int SERVO_IDX_W = 2;
    localparam int STEP_SEL_W  = 2;
    localparam int STEP_AMT_W  = 7;
    // Signed working width: covers duty plus step plus slack, and minimum minus slack.
    localparam int CALC_W      = 19;

    localparam logic [CFG_DATA_W-1:0] LIMITS_RESET = 64'd422212465197057000;

    localparam logic [STEP_SEL_W-1:0] STEP_SEL_SMALL  = 2'd0;
    localparam logic [STEP_SEL_W-1:0] STEP_SEL_MEDIUM = 2'd1;
    localparam logic [STEP_SEL_W-1:0] STEP_SEL_LARGE  = 2'd2;

    typedef enum logic [1:0] {
        DIR_UNKNOWN = 2'd0,
        DIR_DOWN    = 2'd1,
        DIR_UP      = 2'd2
    } dir_t;

    // Layout of one servo limits register.
    typedef struct packed {
        logic [15:0] start;
        logic [15:0] slack;
        logic [15:0] hi;
        logic [15:0] lo;
    } limits_t;

    // What the servo register file shows for the selected servo.
    typedef struct packed {
        limits_t lim;
        dir_t    dir;
    } servo_rd_t;

    // Button edges and step selection for the word in the compute stage.
    typedef struct packed {
        logic                  inc_edge;
        logic                  dec_edge;
        logic [STEP_AMT_W-1:0] step_amt;
        logic [STEP_SEL_W-1:0] step_next;
    } jog_ctrl_t;

    function automatic logic [STEP_AMT_W-1:0] step_amount(input logic [STEP_SEL_W-1:0] sel);
        logic [STEP_AMT_W-1:0] amt;
        case (sel)
            STEP_SEL_SMALL:  amt = 7'd20;
            STEP_SEL_MEDIUM: amt = 7'd40;
            STEP_SEL_LARGE:  amt = 7'd100;
            default:         amt = 7'd20;
        endcase
        return amt;
    endfunction

    function automatic logic [STEP_SEL_W-1:0] step_advance(input logic [STEP_SEL_W-1:0] sel);
        logic [STEP_SEL_W-1:0] nxt;
        case (sel)
            STEP_SEL_SMALL:  nxt = STEP_SEL_MEDIUM;
            STEP_SEL_MEDIUM: nxt = STEP_SEL_LARGE;
            STEP_SEL_LARGE:  nxt = STEP_SEL_SMALL;
            default:         nxt = STEP_SEL_MEDIUM;
        endcase
        return nxt;
    endfunction

endpackage

// ----- sv/sjbc_step_ctrl.sv -----
`timescale 1ns / 1ps
// Shared button latches, edge detection and the step index.
module sjbc_step_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 inc_level,
    input  logic                 dec_level,
    input  logic                 stp_level,
    output sjbc_pkg::jog_ctrl_t  ctrl
);

    logic                            inc_latch_reg;
    logic                            dec_latch_reg;
    logic                            stp_latch_reg;
    logic [sjbc_pkg::STEP_SEL_W-1:0] step_idx_reg;
    logic [sjbc_pkg::STEP_SEL_W-1:0] step_idx_next;
    logic                            stp_edge;

    assign stp_edge      = stp_level && !stp_latch_reg;
    assign step_idx_next = stp_edge ? sjbc_pkg::step_advance(step_idx_reg) : step_idx_reg;

    // The step used by this word is the one selected before its own step edge.
    always_comb begin
        ctrl.inc_edge  = inc_level && !inc_latch_reg;
        ctrl.dec_edge  = dec_level && !dec_latch_reg;
        ctrl.step_amt  = sjbc_pkg::step_amount(step_idx_reg);
        ctrl.step_next = step_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_latch_reg <= 1'b0;
            dec_latch_reg <= 1'b0;
            stp_latch_reg <= 1'b0;
            step_idx_reg  <= sjbc_pkg::STEP_SEL_SMALL;
        end else if (advance) begin
            inc_latch_reg <= inc_level;
            dec_latch_reg <= dec_level;
            stp_latch_reg <= stp_level;
            step_idx_reg  <= step_idx_next;
        end
    end

endmodule

// ----- sv/sjbc_servo_file.sv -----
`timescale 1ns / 1ps
// Per-servo limits, stored duty and last direction, with the configuration write port.
module sjbc_servo_file #(
    parameter int SERVO_COUNT = 4,
    parameter int DUTY_WIDTH  = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [sjbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sjbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [sjbc_pkg::SERVO_IDX_W-1:0] rd_idx,
    output sjbc_pkg::servo_rd_t              rd,
    output logic [DUTY_WIDTH-1:0]            rd_duty,
    input  logic                             upd_en,
    input  logic [DUTY_WIDTH-1:0]            upd_duty,
    input  sjbc_pkg::dir_t                   upd_dir
);

    localparam logic [15:0] DUTY_MAX16 = 16'((1 << DUTY_WIDTH) - 1);

    sjbc_pkg::limits_t lim_reg  [SERVO_COUNT];
    logic [DUTY_WIDTH-1:0] duty_reg [SERVO_COUNT];
    sjbc_pkg::dir_t    dir_reg  [SERVO_COUNT];
    sjbc_pkg::limits_t wr_lim;
    sjbc_pkg::limits_t rst_lim;

    function automatic logic [DUTY_WIDTH-1:0] start_duty(input logic [15:0] v);
        logic [DUTY_WIDTH-1:0] r;
        if (v > DUTY_MAX16) begin
            r = '1;
        end else begin
            r = v[DUTY_WIDTH-1:0];
        end
        return r;
    endfunction

    assign wr_lim  = sjbc_pkg::limits_t'(cfg_wdata);
    assign rst_lim = sjbc_pkg::limits_t'(sjbc_pkg::LIMITS_RESET);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < SERVO_COUNT; i++) begin
            if (!aresetn) begin
                lim_reg[i]  <= rst_lim;
                duty_reg[i] <= start_duty(rst_lim.start);
                dir_reg[i]  <= sjbc_pkg::DIR_UNKNOWN;
            end else if (cfg_we && cfg_index == sjbc_pkg::CFG_IDX_W'(i)) begin
                lim_reg[i]  <= wr_lim;
                duty_reg[i] <= start_duty(wr_lim.start);
            end else if (upd_en && rd_idx == sjbc_pkg::SERVO_IDX_W'(i)) begin
                duty_reg[i] <= upd_duty;
                dir_reg[i]  <= upd_dir;
            end
        end
    end

    always_comb begin
        rd      = '0;
        rd_duty = '0;
        for (int i = 0; i < SERVO_COUNT; i++) begin
            if (rd_idx == sjbc_pkg::SERVO_IDX_W'(i)) begin
                rd.lim  = lim_reg[i];
                rd.dir  = dir_reg[i];
                rd_duty = duty_reg[i];
            end
        end
    end

endmodule

// ----- sv/sjbc_duty_calc.sv -----
`timescale 1ns / 1ps
// Increase and decrease of one servo's duty with clamping and backlash slack.
module sjbc_duty_calc #(
    parameter int DUTY_WIDTH = 16
) (
    input  logic [DUTY_WIDTH-1:0]            duty_in,
    input  sjbc_pkg::servo_rd_t              rd,
    input  logic                             inc_edge,
    input  logic                             dec_edge,
    input  logic [sjbc_pkg::STEP_AMT_W-1:0]  step_amt,
    output logic [DUTY_WIDTH-1:0]            duty_out,
    output sjbc_pkg::dir_t                   dir_out
);

    localparam int CW = sjbc_pkg::CALC_W;
    localparam logic signed [CW-1:0] DUTY_MAX_S = CW'((1 << DUTY_WIDTH) - 1);

    logic signed [CW-1:0] d0, d1, t_inc, t_dec, d2;
    logic signed [CW-1:0] lo_s, hi_s, slack_s, step_s;
    sjbc_pkg::dir_t       dir1;

    function automatic logic signed [CW-1:0] sat(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > DUTY_MAX_S) begin
            r = DUTY_MAX_S;
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_comb begin
        d0      = CW'(duty_in);
        lo_s    = CW'(rd.lim.lo);
        hi_s    = CW'(rd.lim.hi);
        slack_s = CW'(rd.lim.slack);
        step_s  = CW'(step_amt);

        // Increase first; slack is added only when the last move was downward.
        t_inc = d0 + step_s;
        if (t_inc >= hi_s) begin
            t_inc = hi_s;
        end
        if (rd.dir == sjbc_pkg::DIR_DOWN) begin
            t_inc = t_inc + slack_s;
        end
        if (inc_edge) begin
            d1   = sat(t_inc);
            dir1 = sjbc_pkg::DIR_UP;
        end else begin
            d1   = d0;
            dir1 = rd.dir;
        end

        // The decrease then works on whatever the increase left.
        t_dec = d1 - step_s;
        if (t_dec <= lo_s) begin
            t_dec = lo_s;
        end
        if (dir1 == sjbc_pkg::DIR_UP) begin
            t_dec = t_dec - slack_s;
        end
        if (dec_edge) begin
            d2      = sat(t_dec);
            dir_out = sjbc_pkg::DIR_DOWN;
        end else begin
            d2      = d1;
            dir_out = dir1;
        end

        duty_out = d2[DUTY_WIDTH-1:0];
    end

endmodule

// ----- sv/servo_jog_with_backlash_comp.sv -----
`timescale 1ns / 1ps
// Servo jog with shared button edge detection and per-servo backlash compensation.
//
// One word is accepted every clock cycle unless the output is stalled. Its result
// is loaded into the output register once the word has been registered and the
// output is free. The word is registered, then the servo register file is read, the
// new duty is computed and written back, while the result lands in the output
// register at that same edge; that read-modify-write of the servo state is what
// sets the rate of one word per cycle. Configuration writes load a servo's limits
// and reload its duty from the start field at once; there is no clearing pass
// after reset. Words whose servo index is not below SERVO_COUNT leave every duty
// untouched and return duty 0, but still update the button latches and step index.
module servo_jog_with_backlash_comp #(
    parameter int SERVO_COUNT = 4,
    parameter int DUTY_WIDTH  = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [sjbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sjbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sjbc_pkg::SERVO_IDX_W-1:0] s_servo_index,
    input  logic                             s_increase_level,
    input  logic                             s_decrease_level,
    input  logic                             s_step_level,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sjbc_pkg::SERVO_IDX_W-1:0] m_servo_echo,
    output logic [15:0]                      m_duty_value,
    output logic [sjbc_pkg::STEP_SEL_W-1:0]  m_step_select
);

    logic                             in_valid_reg;
    logic [sjbc_pkg::SERVO_IDX_W-1:0] in_servo_reg;
    logic                             in_inc_reg;
    logic                             in_dec_reg;
    logic                             in_stp_reg;

    logic                             out_valid_reg;
    logic [sjbc_pkg::SERVO_IDX_W-1:0] out_servo_reg;
    logic [15:0]                      out_duty_reg;
    logic [sjbc_pkg::STEP_SEL_W-1:0]  out_step_reg;

    logic                  advance;
    logic                  servo_ok;
    sjbc_pkg::jog_ctrl_t   ctrl;
    sjbc_pkg::servo_rd_t   rd;
    logic [DUTY_WIDTH-1:0] rd_duty;
    logic [DUTY_WIDTH-1:0] new_duty;
    sjbc_pkg::dir_t        new_dir;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign servo_ok = {1'b0, in_servo_reg} < 3'(SERVO_COUNT);

    sjbc_step_ctrl u_step_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .inc_level (in_inc_reg),
        .dec_level (in_dec_reg),
        .stp_level (in_stp_reg),
        .ctrl      (ctrl)
    );

    sjbc_servo_file #(
        .SERVO_COUNT (SERVO_COUNT),
        .DUTY_WIDTH  (DUTY_WIDTH)
    ) u_servo_file (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rd_idx    (in_servo_reg),
        .rd        (rd),
        .rd_duty   (rd_duty),
        .upd_en    (advance && servo_ok),
        .upd_duty  (new_duty),
        .upd_dir   (new_dir)
    );

    sjbc_duty_calc #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_duty_calc (
        .duty_in  (rd_duty),
        .rd       (rd),
        .inc_edge (ctrl.inc_edge),
        .dec_edge (ctrl.dec_edge),
        .step_amt (ctrl.step_amt),
        .duty_out (new_duty),
        .dir_out  (new_dir)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_servo_reg <= s_servo_index;
            in_inc_reg   <= s_increase_level;
            in_dec_reg   <= s_decrease_level;
            in_stp_reg   <= s_step_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_servo_reg <= in_servo_reg;
            out_duty_reg  <= servo_ok ? 16'(new_duty) : '0;
            out_step_reg  <= ctrl.step_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_servo_echo  = out_servo_reg;
    assign m_duty_value  = out_duty_reg;
    assign m_step_select = out_step_reg;

    // A word can only be refused while both stages are full and the output is stalled.
    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input refused while the pipeline has room");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("computed word did not reach the output register");

    a_invalid_servo_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ({1'b0, m_servo_echo} >= 3'(SERVO_COUNT))) |-> (m_duty_value == 16'd0))
        else $error("nonzero duty returned for a servo that does not exist");

    a_duty_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_duty_value <= 16'((1 << DUTY_WIDTH) - 1)))
        else $error("duty beyond the duty range");

    a_step_index_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_step_select != 2'd3))
        else $error("step index out of its cycle");

endmodule

// ----- tb/sv/servo_jog_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the servo jog block: tracks servo state, predicts each result and compares.
module servo_jog_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [sjbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sjbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [sjbc_pkg::SERVO_IDX_W-1:0] s_servo_index,
    input  logic                             s_increase_level,
    input  logic                             s_decrease_level,
    input  logic                             s_step_level,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [sjbc_pkg::SERVO_IDX_W-1:0] m_servo_echo,
    input  logic [15:0]                      m_duty_value,
    input  logic [sjbc_pkg::STEP_SEL_W-1:0]  m_step_select,
    output int                               fail_count,
    output int                               awaiting,
    output int                               checked
);
    import sjbc_pkg::*;

    localparam int SERVO_COUNT = 4;
    localparam int DUTY_TOP    = 65535;

    typedef struct packed {
        logic [SERVO_IDX_W-1:0] servo;
        logic [15:0]            duty;
        logic [STEP_SEL_W-1:0]  step;
    } jog_result_t;

    limits_t               servo_limits [SERVO_COUNT];
    logic [15:0]           duty_reg [SERVO_COUNT];
    dir_t                  servo_dir [SERVO_COUNT];
    logic                  inc_held;
    logic                  dec_held;
    logic                  stp_held;
    logic [STEP_SEL_W-1:0] step_sel;
    jog_result_t           expected_duty_q [$];
    jog_result_t           want;

    function automatic int jog_step_size(input logic [STEP_SEL_W-1:0] sel);
        case (sel)
            STEP_SEL_MEDIUM: return 40;
            STEP_SEL_LARGE:  return 100;
            default:         return 20;
        endcase
    endfunction

    function automatic int saturate_duty(input int d);
        if (d < 0) return 0;
        if (d > DUTY_TOP) return DUTY_TOP;
        return d;
    endfunction

    // Applies one accepted word to the tracked state and queues the duty it should produce.
    task automatic apply_jog_word(input logic [SERVO_IDX_W-1:0] servo, input logic inc,
                                  input logic dec, input logic stp);
        int          d;
        int          step;
        limits_t     lim;
        jog_result_t res;
        step = jog_step_size(step_sel);
        lim  = servo_limits[servo];
        d    = int'(duty_reg[servo]);
        if (inc && !inc_held) begin
            d = d + step;
            if (d >= int'(lim.hi)) d = int'(lim.hi);
            if (servo_dir[servo] == DIR_DOWN) d = d + int'(lim.slack);
            servo_dir[servo] = DIR_UP;
            d = saturate_duty(d);
        end
        // A word with both edges applies the increase first, then the decrease.
        if (dec && !dec_held) begin
            d = d - step;
            if (d <= int'(lim.lo)) d = int'(lim.lo);
            if (servo_dir[servo] == DIR_UP) d = d - int'(lim.slack);
            servo_dir[servo] = DIR_DOWN;
            d = saturate_duty(d);
        end
        duty_reg[servo] = 16'(d);
        if (stp && !stp_held) begin
            step_sel = (step_sel == STEP_SEL_LARGE) ? STEP_SEL_SMALL : step_sel + 1'b1;
        end
        inc_held  = inc;
        dec_held  = dec;
        stp_held  = stp;
        res.servo = servo;
        res.duty  = 16'(d);
        res.step  = step_sel;
        expected_duty_q.push_back(res);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SERVO_COUNT; i++) begin
                servo_limits[i] = LIMITS_RESET;
                duty_reg[i]     = servo_limits[i].start;
                servo_dir[i]    = DIR_UNKNOWN;
            end
            inc_held = 1'b0;
            dec_held = 1'b0;
            stp_held = 1'b0;
            step_sel = STEP_SEL_SMALL;
            expected_duty_q.delete();
        end else begin
            // Writing a limits register also reloads that servo's duty from the start field.
            if (cfg_we && int'(cfg_index) < SERVO_COUNT) begin
                servo_limits[cfg_index] = cfg_wdata;
                duty_reg[cfg_index]     = servo_limits[cfg_index].start;
            end
            if (m_valid && m_ready) begin
                if (expected_duty_q.size() == 0) begin
                    $display("%0t: result with no word pending: servo %0d duty %0d step %0d",
                             $time, m_servo_echo, m_duty_value, m_step_select);
                    fail_count++;
                end else begin
                    want = expected_duty_q.pop_front();
                    checked++;
                    if (m_servo_echo !== want.servo) begin
                        $display("%0t: servo_echo mismatch: expected %0d, actual %0d",
                                 $time, want.servo, m_servo_echo);
                        fail_count++;
                    end
                    if (m_duty_value !== want.duty) begin
                        $display("%0t: duty_value mismatch on servo %0d: expected %0d, actual %0d",
                                 $time, want.servo, want.duty, m_duty_value);
                        fail_count++;
                    end
                    if (m_step_select !== want.step) begin
                        $display("%0t: step_select mismatch: expected %0d, actual %0d",
                                 $time, want.step, m_step_select);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_jog_word(s_servo_index, s_increase_level, s_decrease_level, s_step_level);
            end
        end
        awaiting = expected_duty_q.size();
    end

endmodule

// ----- tb/sv/servo_jog_with_backlash_comp_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the servo jog block: clock, reset, stimulus, configuration and verdict.
module servo_jog_with_backlash_comp_tb;
    import sjbc_pkg::*;

    localparam int CLK_PERIOD_NS   = 4;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RAND_PHASES     = 6;
    localparam int WORDS_PER_PHASE = 255;
    localparam int TIMEOUT_NS      = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SERVO0_LIMITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO1_LIMITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO2_LIMITS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO3_LIMITS = 2'd3;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [SERVO_IDX_W-1:0] s_servo_index;
    logic                   s_increase_level;
    logic                   s_decrease_level;
    logic                   s_step_level;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [SERVO_IDX_W-1:0] m_servo_echo;
    logic [15:0]            m_duty_value;
    logic [STEP_SEL_W-1:0]  m_step_select;

    int fail_count;
    int awaiting;
    int checked;
    int words_sent;
    int regs_written;
    int ready_stall;
    bit gaps_on;
    bit stalls_on;

    servo_jog_with_backlash_comp dut (.*);

    servo_jog_checker u_checker (.*);

    always #(CLK_PERIOD_NS / 2) aclk = ~aclk;

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", awaiting);
        $display("Some tests failed");
        $finish;
    end

    // The receiver stalls in bursts of random length.
    always @(negedge aclk) begin
        if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            m_ready     <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            ready_stall <= $urandom_range(0, 2);
            m_ready     <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_levels(input logic [SERVO_IDX_W-1:0] servo, input logic inc,
                               input logic dec, input logic stp);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid          <= 1'b1;
        s_servo_index    <= servo;
        s_increase_level <= inc;
        s_decrease_level <= dec;
        s_step_level     <= stp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // Stops sending and waits until every expected word has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaiting != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limits(input logic [CFG_IDX_W-1:0] idx, input limits_t word);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word;
        regs_written++;
    endtask

    task automatic write_all_limits(input limits_t w0, input limits_t w1,
                                    input limits_t w2, input limits_t w3);
        write_limits(REG_SERVO0_LIMITS, w0);
        write_limits(REG_SERVO1_LIMITS, w1);
        write_limits(REG_SERVO2_LIMITS, w2);
        write_limits(REG_SERVO3_LIMITS, w3);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic limits_t random_limits();
        limits_t lim;
        int      lo;
        int      hi;
        case ($urandom_range(0, 7))
            0: lim = {$urandom, $urandom};
            1: lim = '1;
            2: begin
                // Crowded against the top so that slack saturates high.
                lim.lo    = 16'($urandom_range(64000, 65535));
                lim.hi    = 16'hFFFF;
                lim.slack = 16'($urandom);
                lim.start = 16'($urandom_range(64000, 65535));
            end
            3: begin
                // Crowded against zero so that slack saturates low.
                lim.lo    = 16'd0;
                lim.hi    = 16'($urandom_range(0, 500));
                lim.slack = 16'($urandom_range(100, 65535));
                lim.start = 16'($urandom_range(0, 500));
            end
            4: begin
                // Maximum below minimum, start anywhere.
                hi        = $urandom_range(0, 2000);
                lim.hi    = 16'(hi);
                lim.lo    = 16'(hi + $urandom_range(1, 2000));
                lim.slack = 16'($urandom_range(0, 500));
                lim.start = 16'($urandom_range(0, 5000));
            end
            default: begin
                lo        = $urandom_range(0, 4000);
                hi        = lo + $urandom_range(0, 3000);
                lim.lo    = 16'(lo);
                lim.hi    = 16'(hi);
                lim.slack = 16'($urandom_range(0, 300));
                lim.start = 16'($urandom_range(lo, hi));
            end
        endcase
        return lim;
    endfunction

    initial begin
        aresetn          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_SERVO0_LIMITS;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_servo_index    = '0;
        s_increase_level = 1'b0;
        s_decrease_level = 1'b0;
        s_step_level     = 1'b0;
        gaps_on          = 1'b1;
        stalls_on        = 1'b1;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset limits: first move, reversal, both edges at once, held levels, step wrap.
        send_levels(2'd0, 1'b1, 1'b0, 1'b0);
        send_levels(2'd0, 1'b0, 1'b0, 1'b0);
        send_levels(2'd0, 1'b0, 1'b1, 1'b0);
        send_levels(2'd0, 1'b0, 1'b0, 1'b1);
        send_levels(2'd1, 1'b1, 1'b1, 1'b1);
        send_levels(2'd1, 1'b1, 1'b1, 1'b1);
        send_levels(2'd2, 1'b0, 1'b0, 1'b0);
        send_levels(2'd2, 1'b0, 1'b0, 1'b1);
        send_levels(2'd2, 1'b0, 1'b0, 1'b0);
        send_levels(2'd2, 1'b0, 1'b0, 1'b1);
        drain_results();

        // Extreme limits, each word packed as start, slack, max, min.
        write_all_limits({16'd65530, 16'hFFFF, 16'hFFFF, 16'd0},
                         {16'd3000, 16'd7, 16'd100, 16'd50},
                         {16'd10, 16'd1, 16'hFFFF, 16'd5000},
                         '1);
        send_levels(2'd0, 1'b0, 1'b1, 1'b0);
        send_levels(2'd0, 1'b1, 1'b0, 1'b0);
        send_levels(2'd0, 1'b0, 1'b1, 1'b0);
        send_levels(2'd1, 1'b1, 1'b0, 1'b0);
        send_levels(2'd1, 1'b0, 1'b1, 1'b0);
        send_levels(2'd2, 1'b0, 1'b0, 1'b0);
        send_levels(2'd2, 1'b0, 1'b1, 1'b0);
        send_levels(2'd3, 1'b1, 1'b0, 1'b1);
        send_levels(2'd3, 1'b0, 1'b1, 1'b0);
        send_levels(2'd3, 1'b0, 1'b0, 1'b0);

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            drain_results();
            // The final phase runs with both sides at full rate.
            gaps_on   = (phase != RAND_PHASES - 1);
            stalls_on = (phase != RAND_PHASES - 1);
            write_all_limits((phase == 0) ? limits_t'('0) : random_limits(),
                             random_limits(), random_limits(), random_limits());
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (phase == 1 && n == WORDS_PER_PHASE / 2) drain_results();
                send_levels(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        drain_results();

        $display("Drove %0d words through %0d limit register writes, extremes included.",
                 words_sent, regs_written);
        $display("Compared %0d results on servo echo, duty and step selection.", checked);
        if (fail_count == 0 && awaiting == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
